// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the converter's datapath module.
// They expect a clock named clock and an active-high reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// A condition that holds in the same cycle as its trigger.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A condition that holds in the cycle after its trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/core/itpc_pkg.sv =====
package itpc_pkg;

   // Field widths of the stream channels.
   localparam int FUNC_BITS     = 5;
   localparam int OPERAND_BITS  = 64;
   localparam int ERR_BITS      = 3;
   localparam int RSP_DATA_BITS = 72;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - OPERAND_BITS - ERR_BITS;

   // Token kinds on the input channel. Operator tokens share their code with
   // the operator item that they produce, but for unary plus and minus.
   localparam logic [FUNC_BITS-1:0] TOK_NUMBER      = 5'd0;
   localparam logic [FUNC_BITS-1:0] TOK_PAREN_OPEN  = 5'd1;
   localparam logic [FUNC_BITS-1:0] TOK_PAREN_CLOSE = 5'd2;
   localparam logic [FUNC_BITS-1:0] TOK_ADD         = 5'd3;
   localparam logic [FUNC_BITS-1:0] TOK_SUB         = 5'd4;
   localparam logic [FUNC_BITS-1:0] TOK_NOT         = 5'd5;
   localparam logic [FUNC_BITS-1:0] TOK_MUL         = 5'd6;
   localparam logic [FUNC_BITS-1:0] TOK_DIV         = 5'd7;
   localparam logic [FUNC_BITS-1:0] TOK_MOD         = 5'd8;
   localparam logic [FUNC_BITS-1:0] TOK_POW         = 5'd9;
   localparam logic [FUNC_BITS-1:0] TOK_EQU         = 5'd10;
   localparam logic [FUNC_BITS-1:0] TOK_NEQ         = 5'd11;
   localparam logic [FUNC_BITS-1:0] TOK_LT          = 5'd12;
   localparam logic [FUNC_BITS-1:0] TOK_GT          = 5'd13;
   localparam logic [FUNC_BITS-1:0] TOK_LTE         = 5'd14;
   localparam logic [FUNC_BITS-1:0] TOK_GTE         = 5'd15;
   localparam logic [FUNC_BITS-1:0] TOK_AND         = 5'd16;
   localparam logic [FUNC_BITS-1:0] TOK_OR          = 5'd17;
   localparam logic [FUNC_BITS-1:0] TOK_END         = 5'd18;

   // Result item kinds that are not plain operator codes.
   localparam logic [FUNC_BITS-1:0] KIND_VALUE  = 5'd0;
   localparam logic [FUNC_BITS-1:0] KIND_UPLUS  = 5'd1;
   localparam logic [FUNC_BITS-1:0] KIND_UMINUS = 5'd2;
   localparam logic [FUNC_BITS-1:0] KIND_END    = 5'd18;
   localparam logic [FUNC_BITS-1:0] KIND_ERROR  = 5'd19;

   // A left parenthesis sits on the operator stack under this code.
   localparam logic [FUNC_BITS-1:0] PAREN_MARK  = 5'd0;

   // Error codes.
   localparam logic [ERR_BITS-1:0] ERR_NONE      = 3'd0;
   localparam logic [ERR_BITS-1:0] ERR_PAREN     = 3'd1;
   localparam logic [ERR_BITS-1:0] ERR_NOT_BIN   = 3'd2;
   localparam logic [ERR_BITS-1:0] ERR_BIN_UNARY = 3'd3;
   localparam logic [ERR_BITS-1:0] ERR_OVERFLOW  = 3'd4;

   // What goes into the pending item slot.
   typedef enum logic [1:0] {
      APP_NONE  = 2'd0,
      APP_TOP   = 2'd1,
      APP_ERROR = 2'd2,
      APP_END   = 2'd3
   } itpc_append_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                  latch_tok;
      logic                  push_tok;
      logic                  push_paren;
      logic                  pop;
      logic                  soft_rst;
      logic                  unary_set;
      logic                  unary_clr;
      logic                  out_value;
      logic                  out_error;
      logic [ERR_BITS-1:0]   err;
      itpc_append_type       app;
      logic                  close;
   } itpc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic count_zero;
      logic stack_full;
      logic top_paren;
      logic top_pops;
      logic unary;
      logic pend_valid;
      logic out_free;
   } itpc_status_type;

   // Binding strength of an operator code.
   function automatic logic [3:0] op_prec(input logic [FUNC_BITS-1:0] code);
      logic [3:0] prec;
      unique case (code)
         KIND_UPLUS, KIND_UMINUS, TOK_NOT:         prec = 4'd8;
         TOK_POW:                                  prec = 4'd7;
         TOK_MUL, TOK_DIV, TOK_MOD:                prec = 4'd6;
         TOK_ADD, TOK_SUB:                         prec = 4'd5;
         TOK_LT, TOK_GT, TOK_LTE, TOK_GTE:         prec = 4'd4;
         TOK_EQU, TOK_NEQ:                         prec = 4'd3;
         TOK_AND:                                  prec = 4'd2;
         TOK_OR:                                   prec = 4'd1;
         default:                                  prec = 4'd0;
      endcase
      return prec;
   endfunction

   // Right-associative operators: the unary ones and power.
   function automatic logic op_right(input logic [FUNC_BITS-1:0] code);
      logic right;
      unique case (code)
         KIND_UPLUS, KIND_UMINUS, TOK_NOT, TOK_POW: right = 1'b1;
         default:                                   right = 1'b0;
      endcase
      return right;
   endfunction

endpackage

// ===== rtl/core/infix_to_postfix_converter_unit.sv =====
// Channel   Direction  Carries
// req_      in         infix tokens: tuser token kind, tdata operand value
// rsp_      out        postfix items: tuser item kind, tdata value and error code,
//                      tlast on the final item caused by one token
//
// An operand, a left parenthesis, an operator rejected for its position or an
// unknown token kind is handled in the idle state. A right parenthesis, an
// accepted operator or the end token goes through the decide state, the refetch
// state after every operator popped, as the stack memory's registered read port
// must present the new top, and the close state. Reset is synchronous, sets the
// unary flag, clears the stack count and the controller, not the stack memory.
// While rsp_tready is low the result register holds, and req_tready stays low
// until the converter is idle and the result register is free or draining.
module infix_to_postfix_converter_unit
   import itpc_pkg::*;
#(
   parameter int STACK_DEPTH = 32,
   parameter int VALUE_BITS  = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [OPERAND_BITS-1:0]  req_tdata,   // [63:0] operand_value
   input  logic [FUNC_BITS-1:0]     req_tuser,   // [4:0] func
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // [63:0] item_value, [66:64] error_code
   output logic [FUNC_BITS-1:0]     rsp_tuser,   // [4:0] item_kind
   output logic                     rsp_tlast    // is_last
);

   itpc_cmd_type            cmd;
   itpc_status_type         status;
   logic [OPERAND_BITS-1:0] item_value;
   logic [ERR_BITS-1:0]     error_code;

   // Sequencer for token handling.
   itpc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid_i (req_tvalid),
      .req_ready_o (req_tready),
      .func_i      (req_tuser),
      .status_i    (status),
      .cmd_o       (cmd)
   );

   // Operator stack, pending item and result register.
   itpc_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_BITS  (VALUE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd_i       (cmd),
      .status_o    (status),
      .func_i      (req_tuser),
      .operand_i   (req_tdata),
      .rsp_ready_i (rsp_tready),
      .rsp_valid_o (rsp_tvalid),
      .kind_o      (rsp_tuser),
      .value_o     (item_value),
      .err_o       (error_code),
      .last_o      (rsp_tlast)
   );

   // Pack the result fields, lowest field first, padded to whole bytes.
   assign rsp_tdata = {{RSP_PAD_BITS{1'b0}}, error_code, item_value};

endmodule

// ===== rtl/core/itpc_datapath.sv =====
`include "assert_macros.svh"

module itpc_datapath
   import itpc_pkg::*;
#(
   parameter int STACK_DEPTH = 32,
   parameter int VALUE_BITS  = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  itpc_cmd_type            cmd_i,
   output itpc_status_type         status_o,
   input  logic [FUNC_BITS-1:0]    func_i,
   input  logic [OPERAND_BITS-1:0] operand_i,
   input  logic                    rsp_ready_i,
   output logic                    rsp_valid_o,
   output logic [FUNC_BITS-1:0]    kind_o,
   output logic [OPERAND_BITS-1:0] value_o,
   output logic [ERR_BITS-1:0]     err_o,
   output logic                    last_o
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   // Operator stack memory with a registered read of the top entry.
   logic [FUNC_BITS-1:0] stack_mem [STACK_DEPTH];
   logic [FUNC_BITS-1:0] top_ff;

   logic [CW-1:0]         count_ff, count_in;
   logic                  unary_ff, unary_in;
   logic [FUNC_BITS-1:0]  code_ff, code_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [FUNC_BITS-1:0]  pend_kind_ff, pend_kind_in;
   logic [ERR_BITS-1:0]   pend_err_ff, pend_err_in;
   logic                  out_valid_ff, out_valid_in;
   logic [FUNC_BITS-1:0]  out_kind_ff, out_kind_in;
   logic [VALUE_BITS-1:0] out_value_ff, out_value_in;
   logic [ERR_BITS-1:0]   out_err_ff, out_err_in;
   logic                  out_last_ff, out_last_in;

   logic                  out_free;
   logic                  count_zero;
   logic [CW-1:0]         count_dec;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         wr_addr;
   logic                  stack_we;
   logic [FUNC_BITS-1:0]  stack_wd;
   logic [FUNC_BITS-1:0]  app_kind;
   logic [ERR_BITS-1:0]   app_err;
   logic                  app_any;

   assign out_free   = !out_valid_ff || rsp_ready_i;
   assign count_zero = (count_ff == '0);
   assign count_dec  = count_ff - 1'b1;

   // The read port follows the current top; an empty stack reads entry zero.
   assign rd_addr  = count_zero ? '0 : count_dec[AW-1:0];
   assign wr_addr  = count_ff[AW-1:0];
   assign stack_we = cmd_i.push_tok || cmd_i.push_paren;
   assign stack_wd = cmd_i.push_paren ? PAREN_MARK : code_ff;

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[wr_addr] <= stack_wd;
      end
      top_ff <= stack_mem[rd_addr];
   end

   // Status for the controller.
   always_comb begin
      status_o.count_zero = count_zero;
      status_o.stack_full = (count_ff == CW'(STACK_DEPTH));
      status_o.top_paren  = (top_ff == PAREN_MARK);
      status_o.top_pops   = (op_prec(top_ff) > op_prec(code_ff)) ||
                            ((op_prec(top_ff) == op_prec(code_ff)) && !op_right(code_ff));
      status_o.unary      = unary_ff;
      status_o.pend_valid = pend_valid_ff;
      status_o.out_free   = out_free;
   end

   // Stack count, unary flag and the latched operator code.
   always_comb begin
      count_in = count_ff;
      unary_in = unary_ff;
      code_in  = code_ff;
      if (cmd_i.soft_rst) begin
         count_in = '0;
      end else if (stack_we) begin
         count_in = count_ff + 1'b1;
      end else if (cmd_i.pop) begin
         count_in = count_dec;
      end
      if (cmd_i.soft_rst || cmd_i.unary_set) begin
         unary_in = 1'b1;
      end else if (cmd_i.unary_clr) begin
         unary_in = 1'b0;
      end
      if (cmd_i.latch_tok) begin
         if (unary_ff && func_i == TOK_ADD) begin
            code_in = KIND_UPLUS;
         end else if (unary_ff && func_i == TOK_SUB) begin
            code_in = KIND_UMINUS;
         end else begin
            code_in = func_i;
         end
      end
   end

   // Item that enters the pending slot.
   always_comb begin
      unique case (cmd_i.app)
         APP_TOP: begin
            app_kind = top_ff;
            app_err  = ERR_NONE;
         end
         APP_ERROR: begin
            app_kind = KIND_ERROR;
            app_err  = cmd_i.err;
         end
         APP_END: begin
            app_kind = KIND_END;
            app_err  = ERR_NONE;
         end
         default: begin
            app_kind = KIND_VALUE;
            app_err  = ERR_NONE;
         end
      endcase
      app_any = (cmd_i.app != APP_NONE);
   end

   // The pending slot holds back one item until it is known whether more follow.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_err_in   = pend_err_ff;
      if (app_any) begin
         pend_valid_in = 1'b1;
         pend_kind_in  = app_kind;
         pend_err_in   = app_err;
      end else if (cmd_i.close) begin
         pend_valid_in = 1'b0;
      end
   end

   // Result register.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_value_in = out_value_ff;
      out_err_in   = out_err_ff;
      out_last_in  = out_last_ff;
      priority if (cmd_i.out_value) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_VALUE;
         out_value_in = operand_i[VALUE_BITS-1:0];
         out_err_in   = ERR_NONE;
         out_last_in  = 1'b1;
      end else if (cmd_i.out_error) begin
         out_valid_in = 1'b1;
         out_kind_in  = KIND_ERROR;
         out_value_in = '0;
         out_err_in   = cmd_i.err;
         out_last_in  = 1'b1;
      end else if (app_any && pend_valid_ff) begin
         out_valid_in = 1'b1;
         out_kind_in  = pend_kind_ff;
         out_value_in = '0;
         out_err_in   = pend_err_ff;
         out_last_in  = 1'b0;
      end else if (cmd_i.close) begin
         out_valid_in = 1'b1;
         out_kind_in  = pend_kind_ff;
         out_value_in = '0;
         out_err_in   = pend_err_ff;
         out_last_in  = 1'b1;
      end else begin
         // Nothing new arrives: a held item leaves once it has been taken.
         out_valid_in = out_valid_ff && !rsp_ready_i;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         unary_ff      <= 1'b1;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         unary_ff      <= unary_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      code_ff      <= code_in;
      pend_kind_ff <= pend_kind_in;
      pend_err_ff  <= pend_err_in;
      out_kind_ff  <= out_kind_in;
      out_value_ff <= out_value_in;
      out_err_ff   <= out_err_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid_o = out_valid_ff;
   assign kind_o      = out_kind_ff;
   assign value_o     = OPERAND_BITS'(out_value_ff);
   assign err_o       = out_err_ff;
   assign last_o      = out_last_ff;

   // A pop only ever happens on a non-empty stack.
   `ASSERT_IMPLY(a_pop_nonempty, cmd_i.pop, !count_zero, "pop on an empty operator stack")
   // A push never lands on a full stack.
   `ASSERT_IMPLY(a_push_room, stack_we, count_ff < CW'(STACK_DEPTH), "push onto a full stack")
   // Displacing a pending item needs room in the result register.
   `ASSERT_IMPLY(a_flush_room, app_any && pend_valid_ff, out_free, "pending item overwritten")
   // An error or end returns the stack and unary flag to their reset state.
   `ASSERT_NEXT(a_soft_reset, cmd_i.soft_rst, count_ff == '0 && unary_ff, "soft reset not applied")

endmodule

// ===== rtl/core/itpc_ctrl.sv =====
module itpc_ctrl
   import itpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid_i,
   output logic                 req_ready_o,
   input  logic [FUNC_BITS-1:0] func_i,
   input  itpc_status_type      status_i,
   output itpc_cmd_type         cmd_o
);

   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_DECIDE  = 4'b0010,
      S_REFETCH = 4'b0100,
      S_CLOSE   = 4'b1000
   } itpc_state_type;

   typedef enum logic [1:0] {
      MODE_RPAREN = 2'd0,
      MODE_OP     = 2'd1,
      MODE_END    = 2'd2
   } itpc_mode_type;

   itpc_state_type state_ff, state_in;
   itpc_mode_type  mode_ff, mode_in;
   itpc_cmd_type   cmd_try;
   itpc_state_type next_try;
   logic           accept;

   assign req_ready_o = (state_ff == S_IDLE) && status_i.out_free;
   assign accept      = req_valid_i && req_ready_o;

   // Work out the step for this cycle, then hold it back if the pending item
   // cannot yet move into the result register.
   always_comb begin
      cmd_try  = '0;
      next_try = state_ff;
      mode_in  = mode_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (func_i)
                  TOK_NUMBER: begin
                     cmd_try.out_value = 1'b1;
                     cmd_try.unary_clr = 1'b1;
                  end
                  TOK_PAREN_OPEN: begin
                     if (status_i.stack_full) begin
                        cmd_try.out_error = 1'b1;
                        cmd_try.err       = ERR_OVERFLOW;
                        cmd_try.soft_rst  = 1'b1;
                     end else begin
                        cmd_try.push_paren = 1'b1;
                        cmd_try.unary_set  = 1'b1;
                     end
                  end
                  TOK_PAREN_CLOSE: begin
                     mode_in  = MODE_RPAREN;
                     next_try = S_DECIDE;
                  end
                  TOK_ADD, TOK_SUB: begin
                     cmd_try.latch_tok = 1'b1;
                     mode_in           = MODE_OP;
                     next_try          = S_DECIDE;
                  end
                  TOK_NOT: begin
                     if (status_i.unary) begin
                        cmd_try.latch_tok = 1'b1;
                        mode_in           = MODE_OP;
                        next_try          = S_DECIDE;
                     end else begin
                        cmd_try.out_error = 1'b1;
                        cmd_try.err       = ERR_NOT_BIN;
                        cmd_try.soft_rst  = 1'b1;
                     end
                  end
                  TOK_MUL, TOK_DIV, TOK_MOD, TOK_POW, TOK_EQU, TOK_NEQ,
                  TOK_LT, TOK_GT, TOK_LTE, TOK_GTE, TOK_AND, TOK_OR: begin
                     if (status_i.unary) begin
                        cmd_try.out_error = 1'b1;
                        cmd_try.err       = ERR_BIN_UNARY;
                        cmd_try.soft_rst  = 1'b1;
                     end else begin
                        cmd_try.latch_tok = 1'b1;
                        mode_in           = MODE_OP;
                        next_try          = S_DECIDE;
                     end
                  end
                  TOK_END: begin
                     mode_in  = MODE_END;
                     next_try = S_DECIDE;
                  end
                  default: begin
                     // Unknown token kinds leave no trace.
                  end
               endcase
            end
         end
         S_DECIDE: begin
            unique case (mode_ff)
               MODE_RPAREN: begin
                  if (status_i.count_zero) begin
                     cmd_try.app      = APP_ERROR;
                     cmd_try.err      = ERR_PAREN;
                     cmd_try.soft_rst = 1'b1;
                     next_try         = S_CLOSE;
                  end else if (status_i.top_paren) begin
                     cmd_try.pop       = 1'b1;
                     cmd_try.unary_clr = 1'b1;
                     next_try          = S_CLOSE;
                  end else begin
                     cmd_try.app = APP_TOP;
                     cmd_try.pop = 1'b1;
                     next_try    = S_REFETCH;
                  end
               end
               MODE_OP: begin
                  if (!status_i.count_zero && !status_i.top_paren && status_i.top_pops) begin
                     cmd_try.app = APP_TOP;
                     cmd_try.pop = 1'b1;
                     next_try    = S_REFETCH;
                  end else if (status_i.stack_full) begin
                     cmd_try.app      = APP_ERROR;
                     cmd_try.err      = ERR_OVERFLOW;
                     cmd_try.soft_rst = 1'b1;
                     next_try         = S_CLOSE;
                  end else begin
                     cmd_try.push_tok  = 1'b1;
                     cmd_try.unary_set = 1'b1;
                     next_try          = S_CLOSE;
                  end
               end
               MODE_END: begin
                  if (status_i.count_zero) begin
                     cmd_try.app      = APP_END;
                     cmd_try.soft_rst = 1'b1;
                     next_try         = S_CLOSE;
                  end else if (status_i.top_paren) begin
                     cmd_try.app      = APP_ERROR;
                     cmd_try.err      = ERR_PAREN;
                     cmd_try.soft_rst = 1'b1;
                     next_try         = S_CLOSE;
                  end else begin
                     cmd_try.app = APP_TOP;
                     cmd_try.pop = 1'b1;
                     next_try    = S_REFETCH;
                  end
               end
               default: begin
                  next_try = S_IDLE;
               end
            endcase
         end
         S_REFETCH: begin
            // The registered stack read port presents the new top by the next decide state.
            next_try = S_DECIDE;
         end
         S_CLOSE: begin
            if (!status_i.pend_valid) begin
               next_try = S_IDLE;
            end else if (status_i.out_free) begin
               cmd_try.close = 1'b1;
               next_try      = S_IDLE;
            end
         end
         default: begin
            next_try = S_IDLE;
         end
      endcase
   end

   // Stall a decision that would push out a pending item into a full register.
   always_comb begin
      if (cmd_try.app != APP_NONE && status_i.pend_valid && !status_i.out_free) begin
         cmd_o    = '0;
         state_in = state_ff;
      end else begin
         cmd_o    = cmd_try;
         state_in = next_try;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= MODE_OP;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

endmodule

// ===== tb/testbench.sv =====
module testbench
   import itpc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_DEPTH   = 32;
   localparam int VALUE_BITS    = 64;
   // Sized for the worst single token, which pops a full stack, with margin.
   localparam int SETTLE_CYCLES = 3 + 2 * STACK_DEPTH + 30;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PHASE_TOKENS  = 80;

   // Token kinds that the converter ignores.
   localparam logic [FUNC_BITS-1:0] TOK_UNKNOWN_FIRST = 5'd19;
   localparam logic [FUNC_BITS-1:0] TOK_UNKNOWN_LAST  = 5'd31;

   // One postfix item as it appears on the result channel.
   typedef struct {
      logic [FUNC_BITS-1:0]    kind;
      logic [OPERAND_BITS-1:0] value;
      logic [ERR_BITS-1:0]     err_code;
      logic                    last;
   } postfix_item_type;

   // Tracks the operator stack and the unary flag of the converter, and keeps
   // the postfix items still owed by the block.
   class postfix_tracker_type;
      postfix_item_type     awaited[$];
      postfix_item_type     step_items[$];
      logic [FUNC_BITS-1:0] op_stack[STACK_DEPTH];
      int                   depth;
      bit                   unary;
      int                   mismatches;
      int                   tokens;
      int                   items;
      int                   error_items;
      int                   deepest;

      function new();
         depth = 0;
         unary = 1'b1;
      endfunction

      // Binding strength of an operator code.
      function int binding(logic [FUNC_BITS-1:0] code);
         case (code)
            KIND_UPLUS, KIND_UMINUS, TOK_NOT: return 8;
            TOK_POW:                          return 7;
            TOK_MUL, TOK_DIV, TOK_MOD:        return 6;
            TOK_ADD, TOK_SUB:                 return 5;
            TOK_LT, TOK_GT, TOK_LTE, TOK_GTE: return 4;
            TOK_EQU, TOK_NEQ:                 return 3;
            TOK_AND:                          return 2;
            TOK_OR:                           return 1;
            default:                          return 0;
         endcase
      endfunction

      function bit right_assoc(logic [FUNC_BITS-1:0] code);
         return (code == KIND_UPLUS || code == KIND_UMINUS || code == TOK_NOT ||
                 code == TOK_POW);
      endfunction

      function void emit(logic [FUNC_BITS-1:0] kind, logic [OPERAND_BITS-1:0] value,
                         logic [ERR_BITS-1:0] err_code);
         step_items.push_back('{kind, value, err_code, 1'b0});
      endfunction

      // An error item, after which the converter starts afresh.
      function void fail(logic [ERR_BITS-1:0] err_code);
         emit(KIND_ERROR, '0, err_code);
         depth = 0;
         unary = 1'b1;
      endfunction

      // Works out the items that one accepted token causes.
      function void take_token(logic [FUNC_BITS-1:0] func, logic [OPERAND_BITS-1:0] value);
         logic [FUNC_BITS-1:0] code;
         logic [FUNC_BITS-1:0] top;
         bit                   found;
         bit                   bad;
         step_items.delete();
         tokens++;
         case (func)
            TOK_NUMBER: begin
               emit(KIND_VALUE, value, ERR_NONE);
               unary = 1'b0;
            end
            TOK_PAREN_OPEN: begin
               if (depth >= STACK_DEPTH) begin
                  fail(ERR_OVERFLOW);
               end else begin
                  op_stack[depth] = PAREN_MARK;
                  depth++;
                  unary = 1'b1;
               end
            end
            TOK_PAREN_CLOSE, TOK_END: begin
               // Pop down to the nearest parenthesis or to the bottom.
               found = 1'b0;
               while (depth > 0 && !found) begin
                  top = op_stack[depth-1];
                  depth--;
                  if (top == PAREN_MARK) found = 1'b1;
                  else emit(top, '0, ERR_NONE);
               end
               if (func == TOK_PAREN_CLOSE) begin
                  if (found) unary = 1'b0;
                  else fail(ERR_PAREN);
               end else if (found) begin
                  fail(ERR_PAREN);
               end else begin
                  emit(KIND_END, '0, ERR_NONE);
                  depth = 0;
                  unary = 1'b1;
               end
            end
            default: begin
               if (func >= TOK_ADD && func <= TOK_OR) begin
                  code = func;
                  bad  = 1'b0;
                  if (func == TOK_ADD || func == TOK_SUB) begin
                     if (unary) code = (func == TOK_ADD) ? KIND_UPLUS : KIND_UMINUS;
                  end else if (func == TOK_NOT) begin
                     if (!unary) begin
                        fail(ERR_NOT_BIN);
                        bad = 1'b1;
                     end
                  end else if (unary) begin
                     fail(ERR_BIN_UNARY);
                     bad = 1'b1;
                  end
                  if (!bad) begin
                     while (depth > 0 && op_stack[depth-1] != PAREN_MARK &&
                            (binding(op_stack[depth-1]) > binding(code) ||
                             (binding(op_stack[depth-1]) == binding(code) &&
                              !right_assoc(code)))) begin
                        emit(op_stack[depth-1], '0, ERR_NONE);
                        depth--;
                     end
                     if (depth >= STACK_DEPTH) begin
                        fail(ERR_OVERFLOW);
                     end else begin
                        op_stack[depth] = code;
                        depth++;
                        unary = 1'b1;
                     end
                  end
               end
            end
         endcase
         if (step_items.size() > 0) step_items[step_items.size()-1].last = 1'b1;
         foreach (step_items[i]) awaited.push_back(step_items[i]);
         if (depth > deepest) deepest = depth;
      endfunction

      task flag_mismatch(string msg);
         mismatches++;
         $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      // Compares one received item with the oldest item still owed.
      task match_item(logic [FUNC_BITS-1:0] kind, logic [OPERAND_BITS-1:0] value,
                      logic [ERR_BITS-1:0] err_code, logic last);
         postfix_item_type want;
         items++;
         if (kind == KIND_ERROR) error_items++;
         if (awaited.size() == 0) begin
            flag_mismatch($sformatf("item kind %0d arrived with nothing owed", kind));
         end else begin
            want = awaited.pop_front();
            if (kind !== want.kind)
               flag_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
            if (value !== want.value)
               flag_mismatch($sformatf("value %h, expected %h", value, want.value));
            if (err_code !== want.err_code)
               flag_mismatch($sformatf("error code %0d, expected %0d", err_code,
                                       want.err_code));
            if (last !== want.last)
               flag_mismatch($sformatf("last flag %0b, expected %0b", last, want.last));
         end
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [OPERAND_BITS-1:0]  req_tdata = '0;   // [63:0] operand_value
   logic [FUNC_BITS-1:0]     req_tuser = '0;   // [4:0] func
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;        // [63:0] item_value, [66:64] error_code
   logic [FUNC_BITS-1:0]     rsp_tuser;        // [4:0] item_kind
   logic                     rsp_tlast;

   postfix_tracker_type tracker = new();
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   int                  counted_tokens = 0;
   int                  cycle_count = 0;

   infix_to_postfix_converter_unit #(
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Result side: check each transfer, then choose whether to stall next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.match_item(rsp_tuser, rsp_tdata[OPERAND_BITS-1:0],
                            rsp_tdata[OPERAND_BITS+ERR_BITS-1:OPERAND_BITS], rsp_tlast);
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog on the total run length.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d items owed", cycle_count,
               tracker.awaited.size());
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [OPERAND_BITS-1:0] pick_operand();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Offers one token and returns once its transfer has taken place.
   task automatic send_token(input logic [FUNC_BITS-1:0] func,
                             input logic [OPERAND_BITS-1:0] value = '0);
      // The sender idles cycle by cycle at the current rate before each offer.
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      tracker.take_token(func, value);
      if (func <= TOK_END) counted_tokens++;
   endtask

   // Holds the input back until every owed item has arrived and the block is idle.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A well-formed expression with random content, now and then broken by noise.
   task automatic send_expression();
      int                   nesting;
      int                   operands;
      int                   goal;
      int                   pick;
      bit                   want_operand;
      bit                   done;
      nesting      = 0;
      operands     = 0;
      goal         = $urandom_range(1, 14);
      want_operand = 1'b1;
      done         = 1'b0;
      while (!done) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            send_token(FUNC_BITS'($urandom_range(TOK_UNKNOWN_LAST)), pick_operand());
         end else if (want_operand) begin
            if (pick < 20 && nesting < 6) begin
               send_token(TOK_PAREN_OPEN);
               nesting++;
            end else if (pick < 35) begin
               send_token(FUNC_BITS'($urandom_range(TOK_ADD, TOK_NOT)));
            end else begin
               send_token(TOK_NUMBER, pick_operand());
               operands++;
               want_operand = 1'b0;
            end
         end else if (operands >= goal) begin
            if (nesting > 0) begin
               send_token(TOK_PAREN_CLOSE);
               nesting--;
            end else begin
               send_token(TOK_END);
               done = 1'b1;
            end
         end else if (pick < 20 && nesting > 0) begin
            send_token(TOK_PAREN_CLOSE);
            nesting--;
         end else begin
            pick = $urandom_range(TOK_ADD, TOK_AND);
            if (pick >= TOK_NOT) pick++;
            send_token(FUNC_BITS'(pick));
            want_operand = 1'b1;
         end
      end
   endtask

   // Deep nesting or a long unary chain, around the stack's capacity.
   task automatic send_deep();
      int  levels;
      bit  use_parens;
      levels     = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2);
      use_parens = 1'($urandom_range(1));
      repeat (levels)
         send_token(use_parens ? TOK_PAREN_OPEN :
                                 FUNC_BITS'($urandom_range(TOK_ADD, TOK_NOT)));
      send_token(TOK_NUMBER, pick_operand());
      if (use_parens) repeat (levels) send_token(TOK_PAREN_CLOSE);
      send_token(TOK_END);
   endtask

   initial begin
      int phase;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every operator in one expression, with parentheses and unaries.
      send_token(TOK_NOT);
      send_token(TOK_PAREN_OPEN);
      send_token(TOK_SUB);
      send_token(TOK_NUMBER, '1);
      send_token(TOK_ADD);
      send_token(TOK_NUMBER, '0);
      send_token(TOK_SUB);
      send_token(TOK_NUMBER, 64'd1);
      send_token(TOK_PAREN_CLOSE);
      for (int op = TOK_MUL; op <= TOK_OR; op++) begin
         send_token(FUNC_BITS'(op));
         send_token(TOK_NUMBER, pick_operand());
      end
      send_token(TOK_END);

      // Directed: unmatched right parenthesis, alone and after pending operators.
      send_token(TOK_PAREN_CLOSE);
      send_token(TOK_NUMBER, 64'd5);
      send_token(TOK_ADD);
      send_token(TOK_NUMBER, 64'd6);
      send_token(TOK_PAREN_CLOSE);
      // Not in binary position, then a binary operator in unary position.
      send_token(TOK_NUMBER, 64'd7);
      send_token(TOK_NOT);
      send_token(TOK_MUL);
      // Parenthesis left open at the end of the expression.
      send_token(TOK_PAREN_OPEN);
      send_token(TOK_NUMBER, 64'd8);
      send_token(TOK_ADD);
      send_token(TOK_END);
      // Empty parentheses, operand after operand, binary plus, unknown kinds.
      send_token(TOK_PAREN_OPEN);
      send_token(TOK_PAREN_CLOSE);
      send_token(TOK_NUMBER, pick_operand());
      send_token(TOK_NUMBER, pick_operand());
      send_token(TOK_ADD);
      send_token(TOK_NUMBER, pick_operand());
      send_token(TOK_UNKNOWN_FIRST);
      send_token(TOK_UNKNOWN_LAST);
      send_token(TOK_END);

      // Random: three phases with different idling on the two sides.
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 50 : 0;
         recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 19 : 0;
         wait_drained();
         counted_tokens = 0;
         while (counted_tokens < PHASE_TOKENS) begin
            if ($urandom_range(11) == 0) send_deep();
            else send_expression();
         end
      end
      wait_drained();

      $display("Run covered %0d tokens and %0d postfix items, %0d of them error items;",
               tracker.tokens, tracker.items, tracker.error_items);
      $display("operator stack reached depth %0d of %0d, %0d mismatches.",
               tracker.deepest, STACK_DEPTH, tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/itpc_pkg.sv
rtl/core/itpc_datapath.sv
rtl/core/itpc_ctrl.sv
rtl/core/infix_to_postfix_converter_unit.sv
tb/testbench.sv
